// ===== src/amd_pkg.sv =====
// shared types and constants for the accelerometer magnitude motion detector
package amd_pkg;

  // fixed field widths and constants
  localparam int MAG_W             = 16;
  localparam int SUM_W             = 32;
  localparam int THRESH_W          = 16;
  localparam int ROOT_STEPS        = 16;
  localparam int SQ_LAST           = 3;
  localparam int ONE_G             = 16384;
  localparam int FRACTION_BITS_DEF = 8;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd3277;

  // step count of the two-step divide by five
  localparam int DIV_STEPS         = 2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  // axis select for the shared squarer
  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // configuration register indexes
  typedef enum logic {
    REG_ENABLE    = 1'b0,
    REG_THRESHOLD = 1'b1
  } cfg_reg_t;

  // controller to datapath commands
  typedef struct packed {
    logic  accept;
    logic  sq_mul;
    logic  sq_acc;
    axis_t axis;
    logic  root_step;
    logic  div_load;
    logic  div_step;
    logic  finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic enabled;
    logic started;
    logic out_busy;
  } status_t;

endpackage

// ===== src/amd_ctrl.sv =====
// controller state machine sequencing squaring, square root and smoothing division
module amd_ctrl import amd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int MAX_STEPS = (DIV_STEPS > ROOT_STEPS) ? DIV_STEPS : ROOT_STEPS;
  localparam int CNT_W     = $clog2(MAX_STEPS);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   cnt;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = status.enabled ? ST_SQUARE : ST_DONE;
        end
      end
      ST_SQUARE: begin
        if (cnt == CNT_W'(SQ_LAST)) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          state_next = status.started ? ST_PREP : ST_DONE;
        end
      end
      ST_PREP: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd          = '0;
    cmd.axis     = AXIS_X;
    sample_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        cmd.accept   = sample_valid;
      end
      ST_SQUARE: begin
        cmd.sq_mul = (cnt < CNT_W'(SQ_LAST));
        cmd.sq_acc = (cnt != '0);
        if (cnt == '0) begin
          cmd.axis = AXIS_X;
        end else if (cnt == CNT_W'(1)) begin
          cmd.axis = AXIS_Y;
        end else begin
          cmd.axis = AXIS_Z;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
      end
      ST_PREP: begin
        cmd.div_load = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_DONE: begin
        cmd.finish = !status.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/amd_dp.sv =====
// datapath: config registers, squarer, bit-serial root, reciprocal divide by five, result register
module amd_dp import amd_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [0:0]                 cfg_index,
  input  logic [THRESH_W-1:0]        cfg_data,
  input  logic signed [MAG_W-1:0]    accel_x,
  input  logic signed [MAG_W-1:0]    accel_y,
  input  logic signed [MAG_W-1:0]    accel_z,
  input  cmd_t                       cmd,
  output status_t                    status,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic                       valid_res,
  output logic [MAG_W-1:0]           filtered_magnitude,
  output logic [MAG_W-1:0]           deviation_from_one_g,
  output logic                       motion
);

  localparam int SW       = MAG_W + FRACTION_BITS;
  localparam int SUM_BITS = SW + 3;
  localparam int LO_W     = 16;
  localparam int HI_W     = SUM_BITS - LO_W;
  localparam int PART_W   = ((HI_W > LO_W) ? HI_W : LO_W) + 1;
  localparam int PROD_W   = 2 * PART_W;
  localparam int HI_MUL   = ((1 << LO_W) - 1) / 5;
  localparam int RECIP_SH = PART_W + 2;
  localparam int RECIP    = ((1 << RECIP_SH) + 4) / 5;

  logic                 enabled;
  logic [THRESH_W-1:0]  threshold;
  logic [SW-1:0]        smoothed;
  logic                 started;

  logic [MAG_W-1:0]     abs_x;
  logic [MAG_W-1:0]     abs_y;
  logic [MAG_W-1:0]     abs_z;
  logic [MAG_W-1:0]     sq_in;
  logic [SUM_W-1:0]     prod;
  logic [SUM_W-1:0]     rem;
  logic [SUM_W-1:0]     root;
  logic [SUM_W-1:0]     bitpos;
  logic [SUM_W:0]       trial;
  logic [MAG_W-1:0]     mag;

  logic [SUM_BITS-1:0]  dvd;
  logic [SW-1:0]        part_hi;
  logic [PART_W-1:0]    part_sum;
  logic [PROD_W-1:0]    part_prod;
  logic [SW-1:0]        quo;

  logic [SW-1:0]        avg_new;
  logic [SW-1:0]        one_fx;
  logic [SW-1:0]        dev_fx;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled   <= 1'b0;
      threshold <= THRESH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE:    enabled   <= cfg_data[0];
        REG_THRESHOLD: threshold <= cfg_data;
        default:       enabled   <= enabled;
      endcase
    end
  end

  // operand select for the squarer
  always_comb begin
    case (cmd.axis)
      AXIS_X:  sq_in = abs_x;
      AXIS_Y:  sq_in = abs_y;
      AXIS_Z:  sq_in = abs_z;
      default: sq_in = abs_x;
    endcase
  end

  assign mag   = root[MAG_W-1:0];
  assign trial = {1'b0, root} + {1'b0, bitpos};

  // sample capture, sum of squares and bit-serial square root
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      abs_x  <= accel_x[MAG_W-1] ? MAG_W'(-accel_x) : MAG_W'(accel_x);
      abs_y  <= accel_y[MAG_W-1] ? MAG_W'(-accel_y) : MAG_W'(accel_y);
      abs_z  <= accel_z[MAG_W-1] ? MAG_W'(-accel_z) : MAG_W'(accel_z);
      rem    <= '0;
      root   <= '0;
      bitpos <= SUM_W'(1) << (SUM_W - 2);
    end else begin
      if (cmd.sq_mul) begin
        prod <= SUM_W'(sq_in) * SUM_W'(sq_in);
      end
      if (cmd.sq_acc) begin
        rem <= rem + prod;
      end
      if (cmd.root_step) begin
        if ({1'b0, rem} >= trial) begin
          rem  <= rem - trial[SUM_W-1:0];
          root <= (root >> 1) + bitpos;
        end else begin
          root <= root >> 1;
        end
        bitpos <= bitpos >> 2;
      end
    end
  end

  // folded low part times the reciprocal of five
  assign part_prod = PROD_W'(part_sum) * PROD_W'(RECIP);

  // smoothing division by five: 2^16 = 5 * 13107 + 1 folds the upper part into the
  // lower one, the small folded sum goes through a reciprocal multiply; two steps settle
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd <= (SUM_BITS'(smoothed) << 2) + (SUM_BITS'(mag) << FRACTION_BITS);
    end else if (cmd.div_step) begin
      part_hi  <= SW'(dvd[SUM_BITS-1:LO_W]) * SW'(HI_MUL);
      part_sum <= PART_W'(dvd[SUM_BITS-1:LO_W]) + PART_W'(dvd[LO_W-1:0]);
      quo      <= part_hi + SW'(part_prod >> RECIP_SH);
    end
  end

  // new average and distance from one g
  always_comb begin
    avg_new = started ? quo : (SW'(mag) << FRACTION_BITS);
    one_fx  = SW'(ONE_G) << FRACTION_BITS;
    dev_fx  = (avg_new >= one_fx) ? (avg_new - one_fx) : (one_fx - avg_new);
  end

  // filter state update
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      started  <= 1'b0;
    end else if (cmd.finish && enabled) begin
      smoothed <= avg_new;
      started  <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (enabled) begin
        valid_res            <= 1'b1;
        filtered_magnitude   <= MAG_W'(avg_new >> FRACTION_BITS);
        deviation_from_one_g <= MAG_W'(dev_fx >> FRACTION_BITS);
        motion               <= (dev_fx > (SW'(threshold) << FRACTION_BITS));
      end else begin
        valid_res            <= 1'b0;
        filtered_magnitude   <= '0;
        deviation_from_one_g <= '0;
        motion               <= 1'b0;
      end
    end
  end

  // status back to the controller
  assign status.enabled  = enabled;
  assign status.started  = started;
  assign status.out_busy = result_valid && !result_ready;

endmodule

// ===== src/accel_magnitude_motion_detector_core.sv =====
// Accelerometer magnitude motion detector top level.
// A sample passes through squaring, the bit-serial square root, the sum, the divide-by-five
// and the filter update before its result is valid; the first sample after reset skips the
// divide, a disabled sample goes straight to the result, and a stalled result adds its wait.
// No new sample is taken until the last one is through; the bit-serial root is the longest step.
// Reset: filter average and started flag cleared, sensor disabled, threshold 3277.
module accel_magnitude_motion_detector_core import amd_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [0:0]              cfg_index,
  input  logic [THRESH_W-1:0]     cfg_data,
  input  logic                    sample_valid,
  output logic                    sample_ready,
  input  logic signed [MAG_W-1:0] accel_x,
  input  logic signed [MAG_W-1:0] accel_y,
  input  logic signed [MAG_W-1:0] accel_z,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic                    valid_res,
  output logic [MAG_W-1:0]        filtered_magnitude,
  output logic [MAG_W-1:0]        deviation_from_one_g,
  output logic                    motion
);

  cmd_t    cmd;
  status_t status;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  // sequencing
  amd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // arithmetic and storage
  amd_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .accel_x              (accel_x),
    .accel_y              (accel_y),
    .accel_z              (accel_z),
    .cmd                  (cmd),
    .status               (status),
    .result_valid         (result_valid),
    .result_ready         (result_ready),
    .valid_res            (valid_res),
    .filtered_magnitude   (filtered_magnitude),
    .deviation_from_one_g (deviation_from_one_g),
    .motion               (motion)
  );

endmodule
